// ===== rtl/core/fat16_volume_mount_parser_unit_macros.svh =====
// ---------------------------------------------------------------------------
// fat16_volume_mount_parser_unit_macros.svh
// Assertion macros shared by the mount parser RTL.
// ---------------------------------------------------------------------------
`ifndef FAT16_VOLUME_MOUNT_PARSER_UNIT_MACROS_SVH
`define FAT16_VOLUME_MOUNT_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked property, checked outside reset
`define FVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition that must never hold at a clock edge
`define FVM_ASSERT_NEVER(lbl, cond, msg) \
  `FVM_ASSERT(lbl, !(cond), msg)
`else
`define FVM_ASSERT(lbl, prop, msg)
`define FVM_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ===== rtl/core/fvm_pkg.sv =====
// ---------------------------------------------------------------------------
// fvm_pkg
// Types, codes and constants of the FAT16 volume mount parser.
// ---------------------------------------------------------------------------
package fvm_pkg;

  // request codes on the input beat
  localparam logic [1:0] ReqStart = 2'd0;
  localparam logic [1:0] ReqData  = 2'd1;
  localparam logic [1:0] ReqError = 2'd2;

  // result codes on the output beat
  localparam logic [1:0] KindRead   = 2'd0;
  localparam logic [1:0] KindMount  = 2'd1;
  localparam logic [1:0] KindFailed = 2'd2;

  // sector byte positions
  localparam logic [8:0] IdxJump     = 9'd0;
  localparam logic [8:0] IdxBpsLo    = 9'd11;
  localparam logic [8:0] IdxBpsHi    = 9'd12;
  localparam logic [8:0] IdxCluster  = 9'd13;
  localparam logic [8:0] IdxRsvLo    = 9'd14;
  localparam logic [8:0] IdxRsvHi    = 9'd15;
  localparam logic [8:0] IdxCopies   = 9'd16;
  localparam logic [8:0] IdxRootLo   = 9'd17;
  localparam logic [8:0] IdxRootHi   = 9'd18;
  localparam logic [8:0] IdxSpfLo    = 9'd22;
  localparam logic [8:0] IdxSpfHi    = 9'd23;
  localparam logic [8:0] IdxTag      = 9'h036;
  localparam logic [8:0] IdxTagEnd   = 9'h03e;
  localparam logic [8:0] IdxPart     = 9'h1c6;
  localparam logic [8:0] IdxPartEnd  = 9'h1ca;
  localparam logic [8:0] IdxSigLo    = 9'd510;
  localparam logic [8:0] IdxLast     = 9'd511;

  localparam logic [15:0] SigBoot    = 16'haa55;
  localparam logic [15:0] SigSwapped = 16'h55aa;
  localparam logic [7:0]  JmpNear    = 8'he9;
  localparam logic [7:0]  JmpShort   = 8'heb;
  localparam logic [15:0] Bps512     = 16'h0200;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'b001,
    PH_SECTOR0 = 3'b010,
    PH_BOOT    = 3'b100
  } phase_e;

  // one input beat
  typedef struct packed {
    logic [1:0] req;
    logic [7:0] value;
    logic [8:0] index;
  } item_t;

  // fields captured from the sector being read
  typedef struct packed {
    logic [31:0] part_lba;
    logic        tag_match;
    logic [7:0]  jump;
    logic [15:0] bps;
    logic [7:0]  cluster;
    logic [15:0] reserved;
    logic [7:0]  copies;
    logic [15:0] root_entries;
    logic [15:0] spf;
    logic [15:0] sig;
  } cap_t;

  localparam cap_t CapClear = '{
    part_lba: 32'd0, tag_match: 1'b1, jump: 8'd0, bps: 16'd0, cluster: 8'd0,
    reserved: 16'd0, copies: 8'd0, root_entries: 16'd0, spf: 16'd0, sig: 16'd0
  };

  // one result beat
  typedef struct packed {
    logic        valid;
    logic [1:0]  kind;
    logic [31:0] read_lba;
    logic [7:0]  cluster_sectors;
    logic [31:0] fat_start_lba;
    logic [31:0] root_start_lba;
    logic [12:0] root_dir_sectors;
    logic [31:0] data_start_lba;
  } result_t;

  // expected name tag "FAT16   ", byte k of it
  function automatic logic [7:0] tag_byte(input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = 8'h46;
      3'd1:    b = 8'h41;
      3'd2:    b = 8'h54;
      3'd3:    b = 8'h31;
      3'd4:    b = 8'h36;
      default: b = 8'h20;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/core/fvm_capture.sv =====
// ---------------------------------------------------------------------------
// fvm_capture
// Mount sequencing, field capture and volume layout for one beat a cycle while fire_i is high.
// ---------------------------------------------------------------------------
`include "fat16_volume_mount_parser_unit_macros.svh"

module fvm_capture (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,   // item in the input register is processed
  input  fvm_pkg::item_t   item_i,
  output fvm_pkg::result_t res_o
);

  fvm_pkg::phase_e phase_q, phase_d;
  logic [31:0]     base_q, base_d;
  fvm_pkg::cap_t   cap_q, cap_d;

  // layout partials, kept current with the captured fields
  logic [31:0] fat_start_q;
  logic [23:0] prod_q;
  logic [12:0] rds_q;

  logic [31:0] root_start;
  logic [2:0]  tag_k;
  logic [1:0]  part_lane;
  logic        boot_ok;

  assign tag_k      = 3'(item_i.index - fvm_pkg::IdxTag);
  assign part_lane  = 2'(item_i.index - fvm_pkg::IdxPart);
  assign root_start = fat_start_q + {8'd0, prod_q};

  // next state and result
  always_comb begin
    phase_d = phase_q;
    base_d  = base_q;
    cap_d   = cap_q;
    res_o   = '0;
    boot_ok = 1'b0;
    if (fire_i) begin
      case (item_i.req)
        fvm_pkg::ReqStart: begin
          phase_d     = fvm_pkg::PH_SECTOR0;
          base_d      = 32'd0;
          cap_d       = fvm_pkg::CapClear;
          res_o.valid = 1'b1;
          res_o.kind  = fvm_pkg::KindRead;
        end
        fvm_pkg::ReqData: begin
          if (phase_q != fvm_pkg::PH_IDLE) begin
            // capture the byte
            if (item_i.index == fvm_pkg::IdxJump) cap_d.jump = item_i.value;
            else if (item_i.index == fvm_pkg::IdxBpsLo) cap_d.bps[7:0] = item_i.value;
            else if (item_i.index == fvm_pkg::IdxBpsHi) cap_d.bps[15:8] = item_i.value;
            else if (item_i.index == fvm_pkg::IdxCluster) cap_d.cluster = item_i.value;
            else if (item_i.index == fvm_pkg::IdxRsvLo) cap_d.reserved[7:0] = item_i.value;
            else if (item_i.index == fvm_pkg::IdxRsvHi) cap_d.reserved[15:8] = item_i.value;
            else if (item_i.index == fvm_pkg::IdxCopies) cap_d.copies = item_i.value;
            else if (item_i.index == fvm_pkg::IdxRootLo) cap_d.root_entries[7:0] = item_i.value;
            else if (item_i.index == fvm_pkg::IdxRootHi) cap_d.root_entries[15:8] = item_i.value;
            else if (item_i.index == fvm_pkg::IdxSpfLo) cap_d.spf[7:0] = item_i.value;
            else if (item_i.index == fvm_pkg::IdxSpfHi) cap_d.spf[15:8] = item_i.value;
            else if (item_i.index >= fvm_pkg::IdxTag && item_i.index < fvm_pkg::IdxTagEnd) begin
              if (item_i.value != fvm_pkg::tag_byte(tag_k)) cap_d.tag_match = 1'b0;
            end else if (item_i.index >= fvm_pkg::IdxPart &&
                         item_i.index < fvm_pkg::IdxPartEnd) begin
              case (part_lane)
                2'd0:    cap_d.part_lba[7:0]   = item_i.value;
                2'd1:    cap_d.part_lba[15:8]  = item_i.value;
                2'd2:    cap_d.part_lba[23:16] = item_i.value;
                default: cap_d.part_lba[31:24] = item_i.value;
              endcase
            end else if (item_i.index == fvm_pkg::IdxSigLo) cap_d.sig[7:0] = item_i.value;
            else if (item_i.index == fvm_pkg::IdxLast) cap_d.sig[15:8] = item_i.value;

            // end of sector
            if (item_i.index == fvm_pkg::IdxLast) begin
              res_o.valid = 1'b1;
              if (phase_q == fvm_pkg::PH_SECTOR0 && !cap_d.tag_match) begin
                if (cap_d.sig == fvm_pkg::SigBoot || cap_d.sig == fvm_pkg::SigSwapped) begin
                  // partition table: go read the partition boot sector
                  phase_d        = fvm_pkg::PH_BOOT;
                  base_d         = cap_d.part_lba;
                  res_o.kind     = fvm_pkg::KindRead;
                  res_o.read_lba = cap_d.part_lba;
                  cap_d          = fvm_pkg::CapClear;
                end else begin
                  phase_d    = fvm_pkg::PH_IDLE;
                  res_o.kind = fvm_pkg::KindFailed;
                end
              end else begin
                phase_d = fvm_pkg::PH_IDLE;
                boot_ok = cap_d.tag_match && cap_d.sig == fvm_pkg::SigBoot &&
                          (cap_d.jump == fvm_pkg::JmpNear ||
                           cap_d.jump == fvm_pkg::JmpShort) &&
                          cap_d.bps == fvm_pkg::Bps512;
                if (boot_ok) begin
                  res_o.kind             = fvm_pkg::KindMount;
                  res_o.cluster_sectors  = cap_d.cluster;
                  res_o.fat_start_lba    = fat_start_q;
                  res_o.root_start_lba   = root_start;
                  res_o.root_dir_sectors = rds_q;
                  res_o.data_start_lba   = root_start + {19'd0, rds_q};
                end else begin
                  res_o.kind = fvm_pkg::KindFailed;
                end
              end
            end
          end
        end
        fvm_pkg::ReqError: begin
          if (phase_q != fvm_pkg::PH_IDLE) begin
            phase_d     = fvm_pkg::PH_IDLE;
            res_o.valid = 1'b1;
            res_o.kind  = fvm_pkg::KindFailed;
          end
        end
        default: ;
      endcase
    end
  end

  // control and captured state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= fvm_pkg::PH_IDLE;
      base_q  <= 32'd0;
      cap_q   <= fvm_pkg::CapClear;
    end else begin
      phase_q <= phase_d;
      base_q  <= base_d;
      cap_q   <= cap_d;
    end
  end

  // layout partials from the next captured values; byte 511 touches them only on an MBR hop
  always_ff @(posedge clk_i) begin
    fat_start_q <= base_d + {16'd0, cap_d.reserved};
    prod_q      <= cap_d.copies * cap_d.spf;
    rds_q       <= 13'(({1'b0, cap_d.root_entries} + 17'd15) >> 4);
  end

  `FVM_ASSERT(a_start_reads_zero, fire_i && item_i.req == fvm_pkg::ReqStart |-> res_o.valid && res_o.kind == fvm_pkg::KindRead && res_o.read_lba == 32'd0, "start must request sector zero")
  `FVM_ASSERT(a_final_goes_idle, fire_i && res_o.valid && (res_o.kind == fvm_pkg::KindMount || res_o.kind == fvm_pkg::KindFailed) |=> phase_q == fvm_pkg::PH_IDLE, "final result must leave the parser idle")
  `FVM_ASSERT(a_part_sets_base, fire_i && res_o.valid && res_o.kind == fvm_pkg::KindRead && item_i.req == fvm_pkg::ReqData |=> phase_q == fvm_pkg::PH_BOOT && base_q == $past(res_o.read_lba), "partition request must set base and boot phase")

endmodule

// ===== rtl/core/fvm_out.sv =====
// ---------------------------------------------------------------------------
// fvm_out
// Result register and output beat packing.
// ---------------------------------------------------------------------------
module fvm_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fvm_pkg::result_t res_i,     // valid only on a processed item
  output logic             ready_o,   // register free this cycle
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [151:0]     m_axis_tdata,
  output logic [1:0]       m_axis_tuser
);

  logic             valid_q;
  fvm_pkg::result_t res_q;

  assign ready_o = !valid_q || m_axis_tready;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= res_i.valid;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (ready_o && res_i.valid) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = res_q.kind;
  assign m_axis_tdata  = {3'd0, res_q.data_start_lba, res_q.root_dir_sectors,
                          res_q.root_start_lba, res_q.fat_start_lba,
                          res_q.cluster_sectors, res_q.read_lba};

endmodule

// ===== rtl/core/fat16_volume_mount_parser_unit.sv =====
// ---------------------------------------------------------------------------
// fat16_volume_mount_parser_unit
// Mounts a FAT16 volume from streamed sector bytes: requests sectors, parses
// the MBR and boot sector, and reports the volume layout or a failure.
//
//   channel  dir  tdata                                         tuser
//   s_axis   in   [7:0] byte_value, [16:8] byte_index          req_type
//   m_axis   out  [31:0] read_lba, [39:32] cluster_sectors,     result_kind
//                 [71:40] fat_start_lba, [103:72] root_start_lba,
//                 [116:104] root_dir_sectors, [148:117] data_start_lba
//
// One beat per cycle sustained while m_axis is ready. The input register takes a
// beat, and its parse lands in the result register once that register is free,
// from where the result is offered on m_axis.
// A stalled output holds its result; the input register still takes one more
// beat, and the input stalls only when that one also waits on the output.
// Reset is asynchronous, active low, and leaves the parser idle.
// ---------------------------------------------------------------------------
`include "fat16_volume_mount_parser_unit_macros.svh"

module fat16_volume_mount_parser_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // [7:0] byte_value, [16:8] byte_index
  input  logic [1:0]   s_axis_tuser,   // [1:0] req_type
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [151:0] m_axis_tdata,   // read_lba, cluster_sectors, fat_start_lba,
                                       // root_start_lba, root_dir_sectors,
                                       // data_start_lba (low bits first)
  output logic [1:0]   m_axis_tuser    // [1:0] result_kind
);

  logic             in_valid_q;
  fvm_pkg::item_t   item_q;
  logic             out_ready;
  logic             fire;
  fvm_pkg::result_t res;

  assign fire          = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      item_q <= '{req: s_axis_tuser, value: s_axis_tdata[7:0],
                  index: s_axis_tdata[16:8]};
    end
  end

  fvm_capture u_capture (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (item_q),
    .res_o  (res)
  );

  fvm_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_i         (res),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  `FVM_ASSERT(a_stall_backs_up, in_valid_q && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready && !fire, "input must stall when both stages are held")
  `FVM_ASSERT_NEVER(a_no_fire_empty, fire && !in_valid_q, "processing without an item")

endmodule

// ===== tb/fat16_volume_mount_parser_unit_test.sv =====
// ---------------------------------------------------------------------------
// fat16_volume_mount_parser_unit_test
// Drives start, sector byte and read error beats into the mount parser and
// checks every result beat against a cycle-free model of the mount sequence.
// A short table walks the corner cases first. Random mounts follow, through
// the MBR or straight to the boot sector, with damaged fields, dropped and
// repeated bytes, restarts and stray beats. Both stream sides idle at random.
// ---------------------------------------------------------------------------
module fat16_volume_mount_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // request code with no meaning; the block drops it
  localparam logic [1:0] ReqUnused = 2'd3;
  localparam logic [63:0] FsName = "FAT16   ";

  localparam int PlanRows      = 27;
  localparam int RandomItems   = 600;
  localparam int CycleLimit    = 250000;
  localparam int DrainLimit    = 5000;
  localparam int SettleCycles  = 8;
  localparam int SqueezeAfter  = 150;
  localparam int SqueezeCycles = 200;

  // one input beat; fixed rows carry a typed-in result
  typedef struct packed {
    logic [1:0]  req;
    logic [7:0]  val;
    logic [8:0]  idx;
    bit          fixed;
    logic [1:0]  fixed_kind;
    logic [31:0] fixed_lba;
  } beat_t;

  // one result beat
  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] read_lba;
    logic [7:0]  cluster_sectors;
    logic [31:0] fat_start_lba;
    logic [31:0] root_start_lba;
    logic [12:0] root_dir_sectors;
    logic [31:0] data_start_lba;
  } layout_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata = '0;   // [7:0] byte_value, [16:8] byte_index
  logic [1:0]   s_axis_tuser = '0;   // [1:0] req_type
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [151:0] m_axis_tdata;        // read_lba, cluster_sectors, fat_start_lba,
                                     // root_start_lba, root_dir_sectors,
                                     // data_start_lba (low bits first)
  logic [1:0]   m_axis_tuser;        // [1:0] result_kind

  fat16_volume_mount_parser_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // directed beats: idle drops, restart, an all-ones boot sector, a sector 0
  // with neither name nor signature, an MBR hop, and a read error
  beat_t plan_table [PlanRows] = '{
    '{fvm_pkg::ReqData,  8'hff, fvm_pkg::IdxLast,    1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqError, 8'h00, fvm_pkg::IdxJump,    1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqStart, 8'h00, fvm_pkg::IdxJump,    1'b1, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqStart, 8'hff, fvm_pkg::IdxLast,    1'b1, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  fvm_pkg::JmpNear, fvm_pkg::IdxJump,
      1'b0, fvm_pkg::KindRead, 32'd0},
    '{fvm_pkg::ReqData,  8'h00, fvm_pkg::IdxBpsLo,   1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  8'h02, fvm_pkg::IdxBpsHi,   1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  8'hff, fvm_pkg::IdxCluster, 1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  8'hff, fvm_pkg::IdxRsvLo,   1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  8'hff, fvm_pkg::IdxRsvHi,   1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  8'hff, fvm_pkg::IdxCopies,  1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  8'hff, fvm_pkg::IdxRootLo,  1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  8'hff, fvm_pkg::IdxRootHi,  1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  8'hff, fvm_pkg::IdxSpfLo,   1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  8'hff, fvm_pkg::IdxSpfHi,   1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  8'h55, fvm_pkg::IdxSigLo,   1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  8'haa, fvm_pkg::IdxLast,    1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqStart, 8'h00, fvm_pkg::IdxJump,    1'b1, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  8'h00, fvm_pkg::IdxTag,     1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  8'h00, fvm_pkg::IdxLast,    1'b1, fvm_pkg::KindFailed, 32'd0},
    '{fvm_pkg::ReqStart, 8'h00, fvm_pkg::IdxJump,    1'b1, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  8'hff, fvm_pkg::IdxTag,     1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  8'hff, fvm_pkg::IdxPart + 9'd3,
      1'b0, fvm_pkg::KindRead, 32'd0},
    '{fvm_pkg::ReqData,  8'haa, fvm_pkg::IdxSigLo,   1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqData,  8'h55, fvm_pkg::IdxLast,    1'b0, fvm_pkg::KindRead,   32'd0},
    '{ReqUnused,         8'hff, fvm_pkg::IdxLast,    1'b0, fvm_pkg::KindRead,   32'd0},
    '{fvm_pkg::ReqError, 8'h00, fvm_pkg::IdxJump,    1'b1, fvm_pkg::KindFailed, 32'd0}
  };

  beat_t       beat_q[$];
  layout_t     layout_q[$];
  int unsigned fault_count;
  int unsigned beats_taken;
  int unsigned cycle_count;

  // mount state as the block should hold it
  fvm_pkg::phase_e mnt_phase;
  logic [31:0] vol_base;
  logic [31:0] part_lba;
  logic        tag_ok;
  logic [7:0]  jump_op;
  logic [7:0]  clus_size;
  logic [7:0]  fat_count;
  logic [15:0] sect_bytes;
  logic [15:0] rsv_sects;
  logic [15:0] root_ents;
  logic [15:0] fat_sects;
  logic [15:0] sig_word;

  task automatic clear_boot_fields();
    part_lba   = '0;
    tag_ok     = 1'b1;
    jump_op    = '0;
    clus_size  = '0;
    fat_count  = '0;
    sect_bytes = '0;
    rsv_sects  = '0;
    root_ents  = '0;
    fat_sects  = '0;
    sig_word   = '0;
  endtask

  // advance the mount state by one accepted beat; has_res marks a result
  task automatic advance_mount(input logic [1:0] req, input logic [7:0] val,
                               input logic [8:0] idx, output bit has_res,
                               output layout_t res);
    logic [31:0] fat_lba;
    logic [31:0] root_lba;
    logic [31:0] root_secs;
    logic [2:0]  tag_k;
    res = '0;
    has_res = 1'b0;
    if (req == fvm_pkg::ReqStart) begin
      mnt_phase = fvm_pkg::PH_SECTOR0;
      vol_base = '0;
      clear_boot_fields();
      res.kind = fvm_pkg::KindRead;
      has_res = 1'b1;
    end else if (mnt_phase == fvm_pkg::PH_IDLE || req == ReqUnused) begin
      has_res = 1'b0;
    end else if (req == fvm_pkg::ReqError) begin
      mnt_phase = fvm_pkg::PH_IDLE;
      res.kind = fvm_pkg::KindFailed;
      has_res = 1'b1;
    end else begin
      // field capture
      if (idx == fvm_pkg::IdxJump) jump_op = val;
      else if (idx == fvm_pkg::IdxBpsLo) sect_bytes[7:0] = val;
      else if (idx == fvm_pkg::IdxBpsHi) sect_bytes[15:8] = val;
      else if (idx == fvm_pkg::IdxCluster) clus_size = val;
      else if (idx == fvm_pkg::IdxRsvLo) rsv_sects[7:0] = val;
      else if (idx == fvm_pkg::IdxRsvHi) rsv_sects[15:8] = val;
      else if (idx == fvm_pkg::IdxCopies) fat_count = val;
      else if (idx == fvm_pkg::IdxRootLo) root_ents[7:0] = val;
      else if (idx == fvm_pkg::IdxRootHi) root_ents[15:8] = val;
      else if (idx == fvm_pkg::IdxSpfLo) fat_sects[7:0] = val;
      else if (idx == fvm_pkg::IdxSpfHi) fat_sects[15:8] = val;
      else if (idx >= fvm_pkg::IdxTag && idx < fvm_pkg::IdxTagEnd) begin
        tag_k = 3'(idx - fvm_pkg::IdxTag);
        if (val != FsName[(7 - tag_k) * 8 +: 8]) tag_ok = 1'b0;
      end else if (idx >= fvm_pkg::IdxPart && idx < fvm_pkg::IdxPartEnd) begin
        part_lba[(idx - fvm_pkg::IdxPart) * 8 +: 8] = val;
      end else if (idx == fvm_pkg::IdxSigLo) sig_word[7:0] = val;
      else if (idx == fvm_pkg::IdxLast) sig_word[15:8] = val;

      // sector end: MBR hop or boot sector verdict
      if (idx == fvm_pkg::IdxLast) begin
        has_res = 1'b1;
        if (mnt_phase == fvm_pkg::PH_SECTOR0 && !tag_ok) begin
          if (sig_word == fvm_pkg::SigBoot || sig_word == fvm_pkg::SigSwapped) begin
            res.kind = fvm_pkg::KindRead;
            res.read_lba = part_lba;
            vol_base = part_lba;
            clear_boot_fields();
            mnt_phase = fvm_pkg::PH_BOOT;
          end else begin
            res.kind = fvm_pkg::KindFailed;
            mnt_phase = fvm_pkg::PH_IDLE;
          end
        end else begin
          mnt_phase = fvm_pkg::PH_IDLE;
          if (!tag_ok || sig_word != fvm_pkg::SigBoot || sect_bytes != fvm_pkg::Bps512 ||
              (jump_op != fvm_pkg::JmpNear && jump_op != fvm_pkg::JmpShort)) begin
            res.kind = fvm_pkg::KindFailed;
          end else begin
            fat_lba   = vol_base + {16'd0, rsv_sects};
            root_lba  = fat_lba + {24'd0, fat_count} * {16'd0, fat_sects};
            root_secs = (({16'd0, root_ents} << 5) + 32'd511) >> 9;
            res.kind             = fvm_pkg::KindMount;
            res.cluster_sectors  = clus_size;
            res.fat_start_lba    = fat_lba;
            res.root_start_lba   = root_lba;
            res.root_dir_sectors = root_secs[12:0];
            res.data_start_lba   = root_lba + root_secs;
          end
        end
      end
    end
  endtask

  // stimulus building
  task automatic add_beat(input logic [1:0] req, input logic [7:0] val,
                          input logic [8:0] idx);
    beat_t b;
    b = '{req, val, idx, 1'b0, fvm_pkg::KindRead, 32'd0};
    beat_q.push_back(b);
  endtask

  // one sector byte, now and then dropped or followed by a repeat
  task automatic add_byte(input logic [8:0] idx, input logic [7:0] val);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) return;
    add_beat(fvm_pkg::ReqData, val, idx);
    if (r >= 97) add_beat(fvm_pkg::ReqData, 8'($urandom), idx);
  endtask

  function automatic logic [7:0] maybe_bad(input logic [7:0] good);
    return ($urandom_range(0, 99) < 3) ? 8'($urandom) : good;
  endfunction

  task automatic add_boot_sector();
    logic [15:0] rsv;
    logic [15:0] ents;
    logic [15:0] spf;
    logic [7:0]  clus;
    logic [7:0]  copies;
    int unsigned k;
    rsv    = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 32));
    ents   = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1024));
    spf    = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(1, 256));
    clus   = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'(1 << $urandom_range(0, 7));
    copies = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(1, 2));
    add_byte(fvm_pkg::IdxJump,
             maybe_bad($urandom_range(0, 1) ? fvm_pkg::JmpNear : fvm_pkg::JmpShort));
    add_byte(fvm_pkg::IdxBpsLo, maybe_bad(fvm_pkg::Bps512[7:0]));
    add_byte(fvm_pkg::IdxBpsHi, maybe_bad(fvm_pkg::Bps512[15:8]));
    add_byte(fvm_pkg::IdxCluster, clus);
    add_byte(fvm_pkg::IdxRsvLo, rsv[7:0]);
    add_byte(fvm_pkg::IdxRsvHi, rsv[15:8]);
    add_byte(fvm_pkg::IdxCopies, copies);
    add_byte(fvm_pkg::IdxRootLo, ents[7:0]);
    add_byte(fvm_pkg::IdxRootHi, ents[15:8]);
    add_byte(fvm_pkg::IdxSpfLo, spf[7:0]);
    add_byte(fvm_pkg::IdxSpfHi, spf[15:8]);
    // the name may be present or left out entirely
    if ($urandom_range(0, 1)) begin
      for (k = 0; k < 8; k++) begin
        add_byte(fvm_pkg::IdxTag + 9'(k), maybe_bad(FsName[(7 - k) * 8 +: 8]));
      end
    end
    if ($urandom_range(0, 4) == 0) add_byte(9'($urandom_range(1, 509)), 8'($urandom));
    add_byte(fvm_pkg::IdxSigLo, maybe_bad(fvm_pkg::SigBoot[7:0]));
    add_beat(fvm_pkg::ReqData, maybe_bad(fvm_pkg::SigBoot[15:8]), fvm_pkg::IdxLast);
  endtask

  // sector 0 as an MBR: one name byte spoiled, partition 0 start, signature
  task automatic add_mbr_sector();
    logic [31:0] part;
    int unsigned k;
    int unsigned lane;
    bit          swap;
    case ($urandom_range(0, 3))
      0: part = 32'hffff_ff00 | 32'($urandom_range(0, 255));
      1: part = 32'($urandom_range(0, 255));
      default: part = $urandom;
    endcase
    k = $urandom_range(0, 7);
    add_byte(fvm_pkg::IdxTag + 9'(k),
             FsName[(7 - k) * 8 +: 8] ^ 8'($urandom_range(1, 255)));
    for (lane = 0; lane < 4; lane++) begin
      add_byte(fvm_pkg::IdxPart + 9'(lane), part[lane * 8 +: 8]);
    end
    swap = $urandom_range(0, 1);
    add_byte(fvm_pkg::IdxSigLo,
             maybe_bad(swap ? fvm_pkg::SigSwapped[7:0] : fvm_pkg::SigBoot[7:0]));
    add_beat(fvm_pkg::ReqData,
             maybe_bad(swap ? fvm_pkg::SigSwapped[15:8] : fvm_pkg::SigBoot[15:8]),
             fvm_pkg::IdxLast);
  endtask

  // mostly no gap, some short ones, a few long
  function automatic int unsigned idle_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fault_count++;
    end
  endtask

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("fat16_volume_mount_parser_unit test failed");
      $finish;
    end
  end

  // result side: compare each beat, then pick the next stall
  always @(posedge clk_i) begin : result_side
    layout_t     want;
    bit          squeeze_done;
    int unsigned stall_left;
    if (m_axis_tvalid && m_axis_tready) begin
      if (layout_q.size() == 0) begin
        $display("%0t ns: result beat with none expected, actual kind %0d lba %h",
                 $time, m_axis_tuser, m_axis_tdata[31:0]);
        fault_count++;
      end else begin
        want = layout_q.pop_front();
        check_field("result_kind", 32'(want.kind), 32'(m_axis_tuser));
        check_field("read_lba", want.read_lba, m_axis_tdata[31:0]);
        check_field("cluster_sectors", 32'(want.cluster_sectors), 32'(m_axis_tdata[39:32]));
        check_field("fat_start_lba", want.fat_start_lba, m_axis_tdata[71:40]);
        check_field("root_start_lba", want.root_start_lba, m_axis_tdata[103:72]);
        check_field("root_dir_sectors", 32'(want.root_dir_sectors),
                    32'(m_axis_tdata[116:104]));
        check_field("data_start_lba", want.data_start_lba, m_axis_tdata[148:117]);
      end
    end
    if (rst_ni) begin
      // one long hold-off so the block backs up into its input
      if (!squeeze_done && beats_taken >= SqueezeAfter) begin
        squeeze_done = 1'b1;
        stall_left = SqueezeCycles;
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = idle_gap((cycle_count / 400) % 3 == 1);
      end
    end
  end

  // stimulus, beat side and end of run
  initial begin
    int unsigned gap;
    int unsigned scen;
    int unsigned drain_wait;
    bit          has_res;
    layout_t     res;

    mnt_phase = fvm_pkg::PH_IDLE;
    vol_base = '0;
    clear_boot_fields();

    foreach (plan_table[r]) beat_q.push_back(plan_table[r]);
    while (beat_q.size() < PlanRows + RandomItems) begin
      scen = $urandom_range(0, 9);
      if (scen == 8) begin
        // stray beats of any request code
        repeat ($urandom_range(3, 8)) add_beat(2'($urandom), 8'($urandom), 9'($urandom));
      end else begin
        add_beat(fvm_pkg::ReqStart, 8'($urandom), 9'($urandom));
        case (scen)
          0, 1, 2, 3: begin
            add_mbr_sector();
            add_boot_sector();
          end
          4, 5, 6: begin
            add_boot_sector();
          end
          7: begin
            // read error in the middle of a sector
            if ($urandom_range(0, 1)) add_mbr_sector();
            repeat ($urandom_range(0, 4)) add_byte(9'($urandom_range(0, 510)), 8'($urandom));
            add_beat(fvm_pkg::ReqError, 8'($urandom), 9'($urandom));
          end
          default: begin
            // restart partway through sector 0
            repeat ($urandom_range(1, 5)) add_byte(9'($urandom_range(0, 510)), 8'($urandom));
            add_beat(fvm_pkg::ReqStart, 8'($urandom), 9'($urandom));
            add_boot_sector();
          end
        endcase
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (beat_q[i]) begin
      gap = idle_gap((i / 90) % 3 == 2);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tuser  <= beat_q[i].req;
      s_axis_tdata  <= {7'd0, beat_q[i].idx, beat_q[i].val};
      do @(posedge clk_i); while (!s_axis_tready);
      advance_mount(beat_q[i].req, beat_q[i].val, beat_q[i].idx, has_res, res);
      if (beat_q[i].fixed) begin
        res = '0;
        res.kind = beat_q[i].fixed_kind;
        res.read_lba = beat_q[i].fixed_lba;
        has_res = 1'b1;
      end
      if (has_res) layout_q.push_back(res);
      beats_taken++;
    end
    s_axis_tvalid <= 1'b0;

    drain_wait = 0;
    while (layout_q.size() != 0 && drain_wait < DrainLimit) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (layout_q.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived, first expected kind %0d",
               $time, layout_q.size(), layout_q[0].kind);
      fault_count += layout_q.size();
    end

    if (fault_count == 0) begin
      $display("fat16_volume_mount_parser_unit test passed");
    end else begin
      $display("fat16_volume_mount_parser_unit test failed");
    end
    $finish;
  end

endmodule
